// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; clock and reset are taken as clk_i and rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define GDAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define GDAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- design/gdar_pkg.sv -----
// shared types, widths and constants of the gamepad dead zone / auto-repeat core
// no dependencies
package gdar_pkg;

  localparam int unsigned ButtonBitsDefault = 16;

  localparam int unsigned HeldW    = 16;
  localparam int unsigned AxisW    = 16;
  localparam int unsigned ZoneW    = 15;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned DirW     = 4;
  localparam int unsigned HoldW    = 32;
  localparam int unsigned RepeatW  = 17;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam int unsigned DirUp    = 0;
  localparam int unsigned DirDown  = 1;
  localparam int unsigned DirLeft  = 2;
  localparam int unsigned DirRight = 3;

  localparam logic signed [AxisW-1:0] FullScale = 16'sd32767;
  localparam logic [RepeatW-1:0]      RepeatMax = 17'h1FFFF;

  localparam logic [ZoneW-1:0] DeadZoneRst   = 15'd8000;
  localparam logic [ZoneW-1:0] FullZoneRst   = 15'd30000;
  localparam logic [ZoneW-1:0] DirThreshRst  = 15'd16000;
  localparam logic [TimeW-1:0] FirstDelayRst = 16'd500;
  localparam logic [TimeW-1:0] IntervalRst   = 16'd33;

  typedef enum logic [2:0] {
    RegDeadZone   = 3'd0,
    RegFullZone   = 3'd1,
    RegDirThresh  = 3'd2,
    RegFirstDelay = 3'd3,
    RegInterval   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [ZoneW-1:0] dead_zone;
    logic [ZoneW-1:0] full_zone;
    logic [ZoneW-1:0] dir_thresh;
    logic [TimeW-1:0] first_delay;
    logic [TimeW-1:0] interval;
  } cfg_t;

endpackage

// ----- design/gdar_cfg_regs.sv -----
// configuration register file behind the apb-style port
// depends on gdar_pkg
module gdar_cfg_regs import gdar_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegDeadZone:   cfg_d.dead_zone   = pwdata[ZoneW-1:0];
        RegFullZone:   cfg_d.full_zone   = pwdata[ZoneW-1:0];
        RegDirThresh:  cfg_d.dir_thresh  = pwdata[ZoneW-1:0];
        RegFirstDelay: cfg_d.first_delay = pwdata[TimeW-1:0];
        RegInterval:   cfg_d.interval    = pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDeadZone:   prdata = DataW'(cfg_q.dead_zone);
      RegFullZone:   prdata = DataW'(cfg_q.full_zone);
      RegDirThresh:  prdata = DataW'(cfg_q.dir_thresh);
      RegFirstDelay: prdata = DataW'(cfg_q.first_delay);
      RegInterval:   prdata = DataW'(cfg_q.interval);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone   <= DeadZoneRst;
      cfg_q.full_zone   <= FullZoneRst;
      cfg_q.dir_thresh  <= DirThreshRst;
      cfg_q.first_delay <= FirstDelayRst;
      cfg_q.interval    <= IntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/gdar_axis_zone.sv -----
// dead zone and full zone conditioning of one stick axis
// depends on gdar_pkg
module gdar_axis_zone import gdar_pkg::*; (
  input  logic signed [AxisW-1:0] raw_i,
  input  logic        [ZoneW-1:0] dead_zone_i,
  input  logic        [ZoneW-1:0] full_zone_i,
  output logic signed [AxisW-1:0] zoned_o
);

  logic [AxisW:0] mag;

  // magnitude needs one extra bit for the most negative code
  assign mag = raw_i[AxisW-1] ? ((AxisW+1)'(0) - {raw_i[AxisW-1], raw_i})
                              : {1'b0, raw_i};

  always_comb begin
    if (mag < (AxisW+1)'(dead_zone_i)) begin
      zoned_o = '0;
    end else if (mag > (AxisW+1)'(full_zone_i)) begin
      zoned_o = raw_i[AxisW-1] ? -FullScale : FullScale;
    end else begin
      zoned_o = raw_i;
    end
  end

endmodule

// ----- design/gamepad_deadzone_autorepeat_core.sv -----
// path: an accepted item goes through the input register and the compute pass to the output register
// throughput: one item per cycle; the input register, the single compute pass and
// the result register are all that stand in the way, stalls ripple back through ready
// reset: asynchronous active low; clears valids, edge/hold/repeat state and restores
// the register defaults (dead zone 8000, full zone 30000, threshold 16000, 500, 33)
// depends on gdar_pkg, gdar_cfg_regs and gdar_axis_zone
module gamepad_deadzone_autorepeat_core import gdar_pkg::*; #(
  parameter int unsigned BUTTON_BITS = ButtonBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // frame input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic        [HeldW-1:0] held_buttons_i,
  input  logic signed [AxisW-1:0] raw_stick_x_i,
  input  logic signed [AxisW-1:0] raw_stick_y_i,
  input  logic     [ElapsedW-1:0] elapsed_ms_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic        [HeldW-1:0] pressed_mask_o,
  output logic        [HeldW-1:0] released_mask_o,
  output logic signed [AxisW-1:0] zoned_x_o,
  output logic signed [AxisW-1:0] zoned_y_o,
  output logic         [DirW-1:0] dir_held_o,
  output logic         [DirW-1:0] dir_pressed_o,
  output logic signed [AxisW-1:0] move_x_o,
  output logic signed [AxisW-1:0] move_y_o,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic        [AddrW-1:0] paddr,
  input  logic        [DataW-1:0] pwdata,
  output logic        [DataW-1:0] prdata,
  output logic                    pready
);

  // only the low buttons that fit the 16-bit field are ever seen
  localparam int unsigned HeldBits = (BUTTON_BITS < HeldW) ? BUTTON_BITS : HeldW;

  cfg_t cfg;

  assign pready = 1'b1;

  gdar_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // flow control: input register feeds the compute pass, which writes the
  // result register; while a result waits, the input side takes an item
  // only into an empty input register
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_fire, adv, s2_ready;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign adv        = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s2_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // input register, payload only
  logic        [HeldBits-1:0] s1_held_q;
  logic signed    [AxisW-1:0] s1_x_q, s1_y_q;
  logic        [ElapsedW-1:0] s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_held_q <= held_buttons_i[HeldBits-1:0];
      s1_x_q    <= raw_stick_x_i;
      s1_y_q    <= raw_stick_y_i;
      s1_dt_q   <= elapsed_ms_i;
    end
  end

  // ---------------------------------------------------------------------------
  // compute pass
  // ---------------------------------------------------------------------------
  logic signed [AxisW-1:0] zx, zy;

  gdar_axis_zone u_zone_x (
    .raw_i       (s1_x_q),
    .dead_zone_i (cfg.dead_zone),
    .full_zone_i (cfg.full_zone),
    .zoned_o     (zx)
  );

  gdar_axis_zone u_zone_y (
    .raw_i       (s1_y_q),
    .dead_zone_i (cfg.dead_zone),
    .full_zone_i (cfg.full_zone),
    .zoned_o     (zy)
  );

  // stick directions beyond the threshold, compared in 17-bit signed
  function automatic logic [DirW-1:0] stick_dirs(input logic signed [AxisW-1:0] x,
                                                 input logic signed [AxisW-1:0] y,
                                                 input logic        [ZoneW-1:0] t);
    logic signed [AxisW:0] tp, tn, xe, ye;
    logic [DirW-1:0] d;
    tp = $signed({2'b00, t});
    tn = -tp;
    xe = {x[AxisW-1], x};
    ye = {y[AxisW-1], y};
    d  = '0;
    d[DirUp]    = ye < tn;
    d[DirDown]  = ye > tp;
    d[DirLeft]  = xe < tn;
    d[DirRight] = xe > tp;
    return d;
  endfunction

  // state carried from frame to frame
  logic        [HeldBits-1:0] prev_held_q;
  logic signed    [AxisW-1:0] prev_zx_q, prev_zy_q;
  logic           [HoldW-1:0] hold_q, hold_d;
  logic         [RepeatW-1:0] rep_q, rep_d;

  logic [DirW-1:0]     now_dirs, was_dirs, key_dirs, dheld, dpressed;
  logic [HeldBits-1:0] pressed_raw, released;
  logic [HeldW-1:0]    pressed;
  logic                active, past_delay, fire;
  logic [HoldW:0]      hold_sum;
  logic [HoldW-1:0]    hold_sat;
  logic [RepeatW:0]    rep_sum;
  logic [RepeatW-1:0]  rep_sat, rep_after;
  logic signed [AxisW-1:0] mx, my;

  assign now_dirs = stick_dirs(zx, zy, cfg.dir_thresh);
  assign was_dirs = stick_dirs(prev_zx_q, prev_zy_q, cfg.dir_thresh);
  assign key_dirs = s1_held_q[DirW-1:0];
  assign dheld    = key_dirs | now_dirs;

  assign pressed_raw = s1_held_q & ~prev_held_q;
  assign released    = ~s1_held_q & prev_held_q;

  // hold timer runs while a direction key is down or the y axis is off center
  assign active   = (key_dirs != '0) || (zy != '0);
  assign hold_sum = {1'b0, hold_q} + (HoldW+1)'(s1_dt_q);
  assign hold_sat = hold_sum[HoldW] ? '1 : hold_sum[HoldW-1:0];
  assign hold_d   = active ? hold_sat : '0;

  assign past_delay = hold_d > HoldW'(cfg.first_delay);

  // repeat accumulator, saturating, one interval taken off per repeat
  assign rep_sum   = {1'b0, rep_q} + (RepeatW+1)'(s1_dt_q);
  assign rep_sat   = rep_sum[RepeatW] ? RepeatMax : rep_sum[RepeatW-1:0];
  assign fire      = rep_sat >= RepeatW'(cfg.interval);
  assign rep_after = fire ? (rep_sat - RepeatW'(cfg.interval)) : rep_sat;

  always_comb begin
    if (!active) begin
      rep_d = '0;
    end else if (past_delay) begin
      rep_d = rep_after;
    end else begin
      rep_d = rep_q;
    end
  end

  always_comb begin
    pressed = HeldW'(pressed_raw);
    if (past_delay && fire) begin
      pressed[DirUp]   = pressed[DirUp]   | dheld[DirUp];
      pressed[DirDown] = pressed[DirDown] | dheld[DirDown];
    end
  end

  assign dpressed = pressed[DirW-1:0] | (now_dirs & ~was_dirs);

  // a lone key on an axis overrides the stick with full scale
  always_comb begin
    if (key_dirs[DirLeft] != key_dirs[DirRight]) begin
      mx = key_dirs[DirLeft] ? -FullScale : FullScale;
    end else begin
      mx = zx;
    end
    if (key_dirs[DirUp] != key_dirs[DirDown]) begin
      my = key_dirs[DirUp] ? -FullScale : FullScale;
    end else begin
      my = zy;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      prev_held_q <= '0;
      prev_zx_q   <= '0;
      prev_zy_q   <= '0;
      hold_q      <= '0;
      rep_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        prev_held_q <= s1_held_q;
        prev_zx_q   <= zx;
        prev_zy_q   <= zy;
        hold_q      <= hold_d;
        rep_q       <= rep_d;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pressed_mask_o  <= pressed;
      released_mask_o <= HeldW'(released);
      zoned_x_o       <= zx;
      zoned_y_o       <= zy;
      dir_held_o      <= dheld;
      dir_pressed_o   <= dpressed;
      move_x_o        <= mx;
      move_y_o        <= my;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/gdar_checker.sv -----
// port-level checks of the gamepad core, attached by bind
// depends on gdar_pkg and assert_macros.svh
`include "assert_macros.svh"

module gdar_checker import gdar_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic        [HeldW-1:0] pressed_mask_o,
  input logic        [HeldW-1:0] released_mask_o,
  input logic signed [AxisW-1:0] zoned_x_o,
  input logic         [DirW-1:0] dir_held_o,
  input logic         [DirW-1:0] dir_pressed_o
);

  // no result shows while reset is applied
  `GDAR_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result valid in reset")

  // a stalled result holds
  `GDAR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressed_mask_o) && $stable(zoned_x_o), "stalled result changed")

  // only repeated up/down bits may be pressed and released in one frame
  `GDAR_ASSERT(a_press_release, out_valid_o |-> (pressed_mask_o & released_mask_o & 16'hFFFC) == '0, "button pressed and released together")

  // every direction press is also a held direction
  `GDAR_ASSERT(a_dir_subset, out_valid_o |-> (dir_pressed_o & ~dir_held_o) == '0, "direction pressed but not held")

  // the conditioned axis never takes the most negative code
  `GDAR_ASSERT(a_axis_range, out_valid_o |-> zoned_x_o != 16'sh8000, "zoned axis out of range")

endmodule

bind gamepad_deadzone_autorepeat_core gdar_checker u_gdar_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench of gamepad_deadzone_autorepeat_core: poll frames in, conditioned
// pad state out, checked against a cycle-free predictor of the frame conditioner
// depends on gdar_pkg and the core RTL only
module tb_top;
  import gdar_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one poll frame as it enters the block
  typedef struct packed {
    logic [HeldW-1:0]    held;
    logic [AxisW-1:0]    raw_x;
    logic [AxisW-1:0]    raw_y;
    logic [ElapsedW-1:0] elapsed;
  } poll_frame_t;

  // one conditioned pad state as it leaves the block
  typedef struct packed {
    logic [HeldW-1:0] pressed;
    logic [HeldW-1:0] released;
    logic [AxisW-1:0] zoned_x;
    logic [AxisW-1:0] zoned_y;
    logic [DirW-1:0]  dir_held;
    logic [DirW-1:0]  dir_pressed;
    logic [AxisW-1:0] move_x;
    logic [AxisW-1:0] move_y;
  } pad_state_t;

  // directed row: a frame, and optionally the pad state typed in by hand
  typedef struct packed {
    poll_frame_t frame;
    logic        typed;
    pad_state_t  want;
  } stim_row_t;

  localparam int unsigned NumDirected    = 26;
  localparam int unsigned NumPhases      = 7;
  localparam int unsigned RandomPerPhase = 110;
  localparam int unsigned SaturateBurst  = 140;
  localparam int unsigned LongHoldOff    = 64;
  localparam int unsigned DrainCycles    = 4;
  // address past the last register, writes there must be dropped
  localparam int unsigned RegPastEnd     = 7;

  // hand-written frames: reset state, axis extremes, zone edges, keys, repeat start
  // typed rows: first frame after reset, everything held at the extremes, full release
  stim_row_t directed_rows [NumDirected] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 10'd0}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000}},
    '{'{16'hFFFF, 16'h8000, 16'h7FFF, 10'd0}, 1'b1,
      '{16'hFFFF, 16'h0000, 16'h8001, 16'h7FFF, 4'hF, 4'hF, 16'h8001, 16'h7FFF}},
    '{'{16'h0000, 16'h0000, 16'h0000, 10'd0}, 1'b1,
      '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 4'h0, 4'h0, 16'h0000, 16'h0000}},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd10}, 1'b0, '0},
    '{'{16'h0002, 16'sd0, 16'sd0, 10'd10}, 1'b0, '0},
    '{'{16'h0004, 16'sd0, 16'sd0, 10'd10}, 1'b0, '0},
    '{'{16'h0008, 16'sd0, 16'sd0, 10'd10}, 1'b0, '0},
    '{'{16'h000C, 16'sd5000, 16'sd0, 10'd10}, 1'b0, '0},
    '{'{16'h0000, 16'sd7999, -16'sd7999, 10'd0}, 1'b0, '0},
    '{'{16'h0000, 16'sd8000, -16'sd8000, 10'd0}, 1'b0, '0},
    '{'{16'h0000, 16'sd30000, -16'sd30000, 10'd0}, 1'b0, '0},
    '{'{16'h0000, 16'sd30001, -16'sd30001, 10'd0}, 1'b0, '0},
    '{'{16'h0000, 16'sd16000, 16'sd16000, 10'd0}, 1'b0, '0},
    '{'{16'h0000, 16'sd16001, -16'sd16001, 10'd0}, 1'b0, '0},
    '{'{16'h0000, -16'sd16001, 16'sd16001, 10'd0}, 1'b0, '0},
    '{'{16'hAAA0, 16'sd0, 16'sd0, 10'd1023}, 1'b0, '0},
    '{'{16'h5550, 16'sd0, 16'sd0, 10'd1023}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd200}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd200}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd200}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd200}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd1}, 1'b0, '0},
    '{'{16'h0001, 16'sd0, 16'sd0, 10'd1}, 1'b0, '0},
    '{'{16'h0000, 16'sd0, 16'h8000, 10'd300}, 1'b0, '0},
    '{'{16'h0000, 16'sd0, 16'h8000, 10'd300}, 1'b0, '0},
    '{'{16'h0003, 16'sd0, 16'sd0, 10'd0}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni = 1'b1;

  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [HeldW-1:0]     held_buttons_i = '0;
  logic [AxisW-1:0]     raw_stick_x_i  = '0;
  logic [AxisW-1:0]     raw_stick_y_i  = '0;
  logic [ElapsedW-1:0]  elapsed_ms_i   = '0;

  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [HeldW-1:0]     pressed_mask_o;
  logic [HeldW-1:0]     released_mask_o;
  logic [AxisW-1:0]     zoned_x_o;
  logic [AxisW-1:0]     zoned_y_o;
  logic [DirW-1:0]      dir_held_o;
  logic [DirW-1:0]      dir_pressed_o;
  logic [AxisW-1:0]     move_x_o;
  logic [AxisW-1:0]     move_y_o;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrW-1:0]     paddr   = '0;
  logic [DataW-1:0]     pwdata  = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  gamepad_deadzone_autorepeat_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .held_buttons_i  (held_buttons_i),
    .raw_stick_x_i   (raw_stick_x_i),
    .raw_stick_y_i   (raw_stick_y_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pressed_mask_o  (pressed_mask_o),
    .released_mask_o (released_mask_o),
    .zoned_x_o       (zoned_x_o),
    .zoned_y_o       (zoned_y_o),
    .dir_held_o      (dir_held_o),
    .dir_pressed_o   (dir_pressed_o),
    .move_x_o        (move_x_o),
    .move_y_o        (move_y_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // predictor copy of the registers and of the frame-to-frame state
  cfg_t              shadow_cfg;
  logic [HeldW-1:0]  last_held;
  logic [AxisW-1:0]  last_zoned_x;
  logic [AxisW-1:0]  last_zoned_y;
  logic [HoldW-1:0]  hold_ms;
  logic [RepeatW-1:0] repeat_acc;

  pad_state_t  expected_states [$];
  logic [HeldW-1:0] held_offered;   // held mask of the last frame handed out, for runs

  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_off_req;

  int unsigned frames_sent;
  int unsigned states_checked;
  int unsigned repeat_frames;
  int unsigned settings_used;
  int unsigned mismatch_count;

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1_000_000;
    $display("FAIL gamepad_deadzone_autorepeat_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // dead zone first, so a value inside the dead zone reads zero even if the full zone lies below it
  function automatic logic [AxisW-1:0] zone_axis(input logic [AxisW-1:0] raw);
    int v;
    int mag;
    v   = int'($signed(raw));
    mag = (v < 0) ? -v : v;   // -32768 gives 32768, always past the full zone
    if (mag < int'(shadow_cfg.dead_zone)) return '0;
    if (mag > int'(shadow_cfg.full_zone)) return (v < 0) ? -FullScale : FullScale;
    return raw;
  endfunction

  // directions the zoned stick points past the threshold
  function automatic logic [DirW-1:0] stick_dirs(input logic [AxisW-1:0] zx,
                                                 input logic [AxisW-1:0] zy);
    logic [DirW-1:0] d;
    int t;
    int xi;
    int yi;
    t  = int'(shadow_cfg.dir_thresh);
    xi = int'($signed(zx));
    yi = int'($signed(zy));
    d  = '0;
    d[DirUp]    = (yi < -t);
    d[DirDown]  = (yi > t);
    d[DirLeft]  = (xi < -t);
    d[DirRight] = (xi > t);
    return d;
  endfunction

  // a lone key of the pair gives full scale, otherwise the stick drives movement
  function automatic logic [AxisW-1:0] key_axis(input logic neg, input logic pos,
                                                input logic [AxisW-1:0] stick);
    if (neg != pos) return neg ? -FullScale : FullScale;
    return stick;
  endfunction

  // conditions one poll frame and advances the frame-to-frame state
  function automatic pad_state_t condition_frame(input poll_frame_t f);
    pad_state_t        s;
    logic [AxisW-1:0]  zx;
    logic [AxisW-1:0]  zy;
    logic [DirW-1:0]   now_dirs;
    logic [DirW-1:0]   was_dirs;
    logic [DirW-1:0]   dheld;
    logic [HeldW-1:0]  pressed;
    logic [HoldW:0]    hold_sum;
    logic [RepeatW:0]  acc_sum;
    zx       = zone_axis(f.raw_x);
    zy       = zone_axis(f.raw_y);
    pressed  = f.held & ~last_held;
    now_dirs = stick_dirs(zx, zy);
    was_dirs = stick_dirs(last_zoned_x, last_zoned_y);
    dheld    = f.held[DirW-1:0] | now_dirs;

    // hold timer runs on any direction key or a live vertical stick, saturating
    if (f.held[DirW-1:0] != '0 || zy != '0) begin
      hold_sum = {1'b0, hold_ms} + (HoldW+1)'(f.elapsed);
      hold_ms  = hold_sum[HoldW] ? '1 : hold_sum[HoldW-1:0];
    end else begin
      hold_ms    = '0;
      repeat_acc = '0;
    end

    // past the first delay the accumulator re-fires up/down once per interval;
    // a zero interval fires every frame and never drains
    if (hold_ms > HoldW'(shadow_cfg.first_delay)) begin
      acc_sum = {1'b0, repeat_acc} + (RepeatW+1)'(f.elapsed);
      if (acc_sum > (RepeatW+1)'(RepeatMax)) acc_sum = (RepeatW+1)'(RepeatMax);
      if (acc_sum >= (RepeatW+1)'(shadow_cfg.interval)) begin
        pressed[DirUp]   = pressed[DirUp] | dheld[DirUp];
        pressed[DirDown] = pressed[DirDown] | dheld[DirDown];
        acc_sum = acc_sum - (RepeatW+1)'(shadow_cfg.interval);
        if (dheld[DirUp] || dheld[DirDown]) repeat_frames++;
      end
      repeat_acc = acc_sum[RepeatW-1:0];
    end

    s.pressed     = pressed;
    s.released    = ~f.held & last_held;
    s.zoned_x     = zx;
    s.zoned_y     = zy;
    s.dir_held    = dheld;
    s.dir_pressed = pressed[DirW-1:0] | (now_dirs & ~was_dirs);
    s.move_x      = key_axis(f.held[DirLeft], f.held[DirRight], zx);
    s.move_y      = key_axis(f.held[DirUp], f.held[DirDown], zy);

    last_held    = f.held;
    last_zoned_x = zx;
    last_zoned_y = zy;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // idle length: mostly a short one, now and then a long one
  function automatic int unsigned pick_idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // axis value aimed at the zone and threshold edges of the current setting
  function automatic logic [AxisW-1:0] pick_axis();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = -32768;
      2: v = 32767;
      3: v = int'(shadow_cfg.dead_zone) + int'($urandom_range(0, 2)) - 1;
      4: v = int'(shadow_cfg.full_zone) + int'($urandom_range(0, 2)) - 1;
      5: v = int'(shadow_cfg.dir_thresh) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v >= 0 && v <= 32767 && $urandom_range(0, 1) == 1) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[AxisW-1:0];
  endfunction

  // held masks mostly run on from the last frame so the hold timer gets going
  function automatic poll_frame_t random_frame();
    poll_frame_t f;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) f.held = held_offered;
    else if (r < 65) f.held = held_offered ^ (HeldW'(1) << $urandom_range(0, HeldW - 1));
    else if (r < 80) f.held = HeldW'($urandom_range(0, 15));
    else f.held = HeldW'($urandom_range(0, 65535));
    f.raw_x = pick_axis();
    f.raw_y = pick_axis();
    r = $urandom_range(0, 99);
    if (r < 55) f.elapsed = ElapsedW'($urandom_range(0, 40));
    else if (r < 90) f.elapsed = ElapsedW'($urandom_range(41, 300));
    else f.elapsed = ElapsedW'($urandom_range(0, 1023));
    return f;
  endfunction

  // offers one frame and waits for it to be taken; valid stays up between
  // back-to-back items and only drops when a gap is chosen
  task automatic send_frame(input poll_frame_t f, input logic typed, input pad_state_t want);
    int unsigned gap;
    pad_state_t  s;
    gap = (tx_idle_en && $urandom_range(0, 99) < 40) ? pick_idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    held_buttons_i <= f.held;
    raw_stick_x_i  <= f.raw_x;
    raw_stick_y_i  <= f.raw_y;
    elapsed_ms_i   <= f.elapsed;
    held_offered    = f.held;
    do @(posedge clk_i); while (!in_ready_o);
    s = condition_frame(f);
    expected_states.push_back(typed ? want : s);
    frames_sent++;
  endtask

  // lets every outstanding item come out before the registers change
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk_i);
  endtask

  // one APB write: setup then access; psel stays up across back-to-back writes
  task automatic write_reg(input int unsigned idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegDeadZone:   shadow_cfg.dead_zone   = value[ZoneW-1:0];
      RegFullZone:   shadow_cfg.full_zone   = value[ZoneW-1:0];
      RegDirThresh:  shadow_cfg.dir_thresh  = value[ZoneW-1:0];
      RegFirstDelay: shadow_cfg.first_delay = value[TimeW-1:0];
      RegInterval:   shadow_cfg.interval    = value[TimeW-1:0];
      default: ;   // past the register list, dropped
    endcase
  endtask

  task automatic write_setting(input int unsigned dz, input int unsigned fz,
                               input int unsigned th, input int unsigned fd,
                               input int unsigned iv);
    write_reg(RegDeadZone, dz);
    write_reg(RegFullZone, fz);
    write_reg(RegDirThresh, th);
    write_reg(RegFirstDelay, fd);
    write_reg(RegInterval, iv);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [HeldW-1:0] want,
                             input logic [HeldW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // compares the pad state on the output with the oldest prediction
  task automatic check_state();
    pad_state_t want;
    if (expected_states.size() == 0) begin
      $error("pad state with no frame outstanding");
      mismatch_count++;
      return;
    end
    want = expected_states.pop_front();
    check_field("pressed_mask", want.pressed, pressed_mask_o);
    check_field("released_mask", want.released, released_mask_o);
    check_field("zoned_x", want.zoned_x, zoned_x_o);
    check_field("zoned_y", want.zoned_y, zoned_y_o);
    check_field("dir_held", HeldW'(want.dir_held), HeldW'(dir_held_o));
    check_field("dir_pressed", HeldW'(want.dir_pressed), HeldW'(dir_pressed_o));
    check_field("move_x", want.move_x, move_x_o);
    check_field("move_y", want.move_y, move_y_o);
    states_checked++;
  endtask

  // result side: checks on every handshake, then picks ready for the next cycle;
  // a requested hold-off keeps ready low long enough to back the block up
  initial begin : state_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_state();
      if (hold_off_req) begin
        stall_left   = LongHoldOff;
        hold_off_req = 1'b0;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        stall_left   = pick_idle_len() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : frame_source
    poll_frame_t f;
    shadow_cfg     = '{DeadZoneRst, FullZoneRst, DirThreshRst, FirstDelayRst, IntervalRst};
    last_held      = '0;
    last_zoned_x   = '0;
    last_zoned_y   = '0;
    hold_ms        = '0;
    repeat_acc     = '0;
    held_offered   = '0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    hold_off_req   = 1'b0;
    frames_sent    = 0;
    states_checked = 0;
    repeat_frames  = 0;
    settings_used  = 1;
    mismatch_count = 0;

    // falling edge once every process is running, so the async reset takes hold
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-written frames at the reset setting
    foreach (directed_rows[i])
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          // everything at zero: every nonzero axis snaps, repeat fires whenever the hold timer is nonzero
          1: begin
            write_setting(0, 0, 0, 0, 0);
            write_reg(RegPastEnd, '1);
          end
          // everything at the top
          2: write_setting(32767, 32767, 32767, 65535, 65535);
          // full zone under the dead zone, tightest legal interval
          3: write_setting(20000, 10000, 5000, 100, 1);
          default: write_setting($urandom_range(0, 12000), $urandom_range(20000, 32767),
                                 $urandom_range(0, 32767), $urandom_range(0, 1000),
                                 $urandom_range(1, 100));
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
      end

      // phase 1 runs with no idling at all, phase 2 keeps the sender busy while the
      // receiver sits out a long stretch
      tx_idle_en = (phase != 1 && phase != 2);
      rx_idle_en = (phase != 1);
      if (phase == 2) hold_off_req = 1'b1;

      // long hold of up with big steps drives the accumulator into saturation
      if (phase == 1) begin
        for (int unsigned n = 0; n < SaturateBurst; n++) begin
          f         = random_frame();
          f.held    = HeldW'(1) << DirUp;
          f.elapsed = '1;
          send_frame(f, 1'b0, '0);
        end
      end

      for (int unsigned n = 0; n < RandomPerPhase; n++) send_frame(random_frame(), 1'b0, '0);
    end

    rx_idle_en = 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d poll frames under %0d register settings, %0d pad states checked",
             frames_sent, settings_used, states_checked);
    $display("%0d frames carried auto-repeat presses, %0d field mismatches",
             repeat_frames, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS gamepad_deadzone_autorepeat_core");
    end else begin
      $display("FAIL gamepad_deadzone_autorepeat_core");
    end
    $finish;
  end

endmodule
